/* sv/line_framer_cr_lf_top_macros.svh */
// Assertion macros shared by the line framer RTL files.
// The macros expect a signal named clk, and LFCL_ASSERT also rst, in the module that uses them.
`ifndef LINE_FRAMER_CR_LF_TOP_MACROS_SVH
`define LINE_FRAMER_CR_LF_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define LFCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define LFCL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LFCL_ASSERT(label, prop, msg)
`define LFCL_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/lfcl_pkg.sv */
// Shared types and constants for the CR/LF line framer.
// No dependencies; imported by every module of the block.
package lfcl_pkg;

  localparam int LINE_BYTES_DEFAULT = 64;
  localparam int STORE_DEPTH        = 64;
  localparam int CNT_W              = 6;
  localparam int CQ_DEPTH           = 2;
  localparam int CQ_AW              = 1;
  localparam int OQ_DEPTH           = 4;
  localparam int OQ_AW              = 2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [1:0] {
    KIND_ECHO     = 2'd0,
    KIND_LINE     = 2'd1,
    KIND_EMPTY    = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_FLUSH    = 2'd1,
    OP_OVERFLOW = 2'd2
  } op_t;

  // Work handed from the front end to the back end.
  // For OP_WRITE, arg is the store address; for OP_FLUSH, the line length.
  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [CNT_W-1:0] arg;
    logic             echo;
  } cmd_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data_byte;
    logic [CNT_W-1:0] line_length;
    logic             last;
  } res_t;

endpackage

/* sv/lfcl_cmdq.sv */
// Two-entry command queue between the front end and the back end.
// Depends on lfcl_pkg for cmd_t and the queue depth.
`include "line_framer_cr_lf_top_macros.svh"
module lfcl_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lfcl_pkg::cmd_t wr_cmd,
  output logic          full,
  output logic          rd_valid,
  output lfcl_pkg::cmd_t rd_cmd,
  input  logic          rd_en
);
  import lfcl_pkg::*;

  cmd_t             slots [0:CQ_DEPTH-1];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   count;

  assign full     = (count == (CQ_AW+1)'(CQ_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  `LFCL_ASSERT(a_cq_no_underflow, rd_en |-> rd_valid, "command queue popped while empty")
  `LFCL_ASSERT(a_cq_no_overflow, wr_en |-> !full, "command queue pushed while full")

endmodule

/* sv/lfcl_front.sv */
// Front end: accepts bytes, tracks line length and the CR flag, issues commands.
// Depends on lfcl_pkg for cmd_t, op codes and character constants.
`include "line_framer_cr_lf_top_macros.svh"
module lfcl_front #(
  parameter int LINE_BYTES = lfcl_pkg::LINE_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic [7:0]     rx_byte,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           cq_full,
  output logic           cmd_push,
  output lfcl_pkg::cmd_t cmd
);
  import lfcl_pkg::*;

  localparam int CAP = ((LINE_BYTES - 1) > 63) ? 63 : (LINE_BYTES - 1);

  logic             echo_enable;
  logic [CNT_W-1:0] line_count;
  logic [CNT_W-1:0] line_count_next;
  logic             after_cr;
  logic             after_cr_next;
  logic             accept;
  logic             is_delim;
  logic             is_swallow;
  logic             is_full;

  assign accept     = push && !cq_full;
  assign is_delim   = (rx_byte == CH_CR) || ((rx_byte == CH_LF) && !after_cr);
  assign is_swallow = (rx_byte == CH_LF) && after_cr;
  assign is_full    = (line_count >= CNT_W'(CAP));

  always_comb begin
    cmd_push        = 1'b0;
    cmd.op          = OP_WRITE;
    cmd.data        = rx_byte;
    cmd.arg         = line_count;
    cmd.echo        = echo_enable;
    line_count_next = line_count;
    after_cr_next   = 1'b0;
    if (accept) begin
      if (is_delim) begin
        cmd_push        = 1'b1;
        cmd.op          = OP_FLUSH;
        line_count_next = '0;
        after_cr_next   = (rx_byte == CH_CR);
      end else if (is_swallow) begin
        cmd_push = 1'b0;
      end else if (is_full) begin
        cmd_push        = 1'b1;
        cmd.op          = OP_OVERFLOW;
        line_count_next = '0;
      end else begin
        cmd_push        = 1'b1;
        line_count_next = line_count + 1'b1;
      end
    end else begin
      after_cr_next = after_cr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b0;
      line_count  <= '0;
      after_cr    <= 1'b0;
    end else begin
      if (cfg_we) begin
        echo_enable <= cfg_wdata;
      end
      line_count <= line_count_next;
      after_cr   <= after_cr_next;
    end
  end

  `LFCL_ASSERT(a_fr_count_cap, line_count <= CNT_W'(CAP), "line count above capacity")

endmodule

/* sv/lfcl_back.sv */
// Back end: executes commands, owns the line store and the result queue.
// Depends on lfcl_pkg for cmd_t, res_t, kind codes and queue sizes.
`include "line_framer_cr_lf_top_macros.svh"
module lfcl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  lfcl_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           empty,
  output lfcl_pkg::res_t res,
  input  logic           pop
);
  import lfcl_pkg::*;

  logic [7:0]       store [0:STORE_DEPTH-1];
  logic [7:0]       store_q;

  logic             draining;
  logic [CNT_W-1:0] drain_idx;
  logic [CNT_W-1:0] drain_len;
  logic             drain_end;

  // Result stage: one result a cycle into the output queue while it has room.
  logic             res_valid;
  kind_t            res_kind;
  logic             res_from_mem;
  logic [7:0]       res_data;
  logic [CNT_W-1:0] res_len;
  logic             res_last;

  res_t             oq [0:OQ_DEPTH-1];
  logic [OQ_AW-1:0] oq_wr;
  logic [OQ_AW-1:0] oq_rd;
  logic [OQ_AW:0]   oq_count;
  logic             oq_pop;
  logic             can_issue;
  logic             store_we;
  logic             store_re;

  assign can_issue = ((oq_count + (OQ_AW+1)'(res_valid)) < (OQ_AW+1)'(OQ_DEPTH));
  assign drain_end = (drain_idx == (drain_len - 1'b1));
  assign cmd_pop   = cmd_valid && can_issue && !draining;
  assign store_we  = cmd_pop && (cmd.op == OP_WRITE);
  assign store_re  = draining && can_issue;
  assign oq_pop    = pop && !empty;
  assign empty     = (oq_count == '0);
  assign res       = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[cmd.arg] <= cmd.data;
    end
    if (store_re) begin
      store_q <= store[drain_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      if (store_re) begin
        res_valid    <= 1'b1;
        res_kind     <= KIND_LINE;
        res_from_mem <= 1'b1;
        res_data     <= '0;
        res_len      <= drain_len;
        res_last     <= drain_end;
        drain_idx    <= drain_idx + 1'b1;
        if (drain_end) begin
          draining <= 1'b0;
        end
      end else if (cmd_pop) begin
        res_from_mem <= 1'b0;
        res_data     <= '0;
        res_len      <= '0;
        res_last     <= 1'b1;
        case (cmd.op)
          OP_WRITE: begin
            res_valid <= cmd.echo;
            res_kind  <= KIND_ECHO;
            res_data  <= cmd.data;
          end
          OP_FLUSH: begin
            if (cmd.arg == '0) begin
              res_valid <= 1'b1;
              res_kind  <= KIND_EMPTY;
            end else begin
              draining  <= 1'b1;
              drain_idx <= '0;
              drain_len <= cmd.arg;
            end
          end
          OP_OVERFLOW: begin
            res_valid <= 1'b1;
            res_kind  <= KIND_OVERFLOW;
          end
          default: begin
            res_valid <= 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (res_valid) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      if (res_valid && !oq_pop) begin
        oq_count <= oq_count + 1'b1;
      end else if (!res_valid && oq_pop) begin
        oq_count <= oq_count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      oq[oq_wr].kind        <= res_kind;
      oq[oq_wr].data_byte   <= res_from_mem ? store_q : res_data;
      oq[oq_wr].line_length <= res_len;
      oq[oq_wr].last        <= res_last;
    end
  end

  `LFCL_ASSERT(a_bk_oq_room, res_valid |-> (oq_count < (OQ_AW+1)'(OQ_DEPTH)),
    "result queue written while full")
  `LFCL_ASSERT(a_bk_drain_range, draining |-> (drain_idx < drain_len),
    "drain index past line length")
  `LFCL_ASSERT(a_bk_no_cmd_drain, draining |-> !cmd_pop,
    "command taken while a line drains")

endmodule

/* sv/line_framer_cr_lf_top.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------
// input     | push / full        | rx_byte[7:0]
// results   | empty / pop        | kind[1:0], data_byte[7:0],
//           |                    | line_length[5:0], last
// config    | cfg_we             | cfg_wdata (echo enable)
//
// An ordinary byte, a delimiter or a swallowed LF is taken whenever the
// two-entry command queue has room. A line of N bytes is read out of the line
// store by the back end at one byte a cycle while the result queue has room, so
// after taking a delimiter the back end takes no other command until the line
// is read out, and input stalls once the command queue fills behind it.
// Reset is synchronous and active high; the line store needs no clearing pass.
// Either side may stall at any time; the four-entry result queue absorbs it.
//
// Top level of the CR/LF line framer: front end, command queue and back end.
// Depends on lfcl_pkg and the three submodules.
module line_framer_cr_lf_top #(
  parameter int LINE_BYTES = lfcl_pkg::LINE_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  // Input request channel.
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  // Result request channel.
  output logic       empty,
  input  logic       pop,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [5:0] line_length,
  output logic       last,
  // Configuration: the echo enable register.
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import lfcl_pkg::*;

  // The front end classifies each request and updates the line length and
  // CR flag at once; the back end owns the store and produces results.
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  cmd_t cmd_head;
  logic cmd_pop;
  res_t res;

  lfcl_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cq_full  (full),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Commands are kept in order, so store writes for a new line always follow
  // the read-out of the previous one.
  lfcl_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_cmd  (cmd_in),
    .full    (full),
    .rd_valid(cmd_valid),
    .rd_cmd  (cmd_head),
    .rd_en   (cmd_pop)
  );

  lfcl_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .empty    (empty),
    .res      (res),
    .pop      (pop)
  );

  assign kind        = res.kind;
  assign data_byte   = res.data_byte;
  assign line_length = res.line_length;
  assign last        = res.last;

endmodule
